@@ sv/hall_bldc_assisted_start_commutator_defines.svh @@
// assertion helpers for the start commutator, sampled on clk and held off during rst_n
`ifndef HALL_BLDC_ASSISTED_START_COMMUTATOR_DEFINES_SVH
`define HALL_BLDC_ASSISTED_START_COMMUTATOR_DEFINES_SVH

// same-cycle implication
`define HBAC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hbac check failed");

// next-cycle implication
`define HBAC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hbac check failed");

`endif

@@ sv/hbac_pkg.sv @@
`default_nettype none
package hbac_pkg;

  localparam int DUTY_W  = 16;
  localparam int MS_W    = 10;
  localparam int HALL_W  = 3;
  localparam int STAGE_W = 3;
  localparam int KICK_W  = 3;
  localparam int FAULT_W = 2;
  localparam int OP_W    = 3;
  localparam int CFG_IDX_W = 2;

  // operation codes
  localparam logic [OP_W-1:0] OP_START_SIMPLE = 3'd0;
  localparam logic [OP_W-1:0] OP_START_ASSIST = 3'd1;
  localparam logic [OP_W-1:0] OP_STOP         = 3'd2;
  localparam logic [OP_W-1:0] OP_TICK         = 3'd3;
  localparam logic [OP_W-1:0] OP_HALL_EDGE    = 3'd4;
  localparam logic [OP_W-1:0] OP_SET_DUTY     = 3'd5;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PWM_PERIOD   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALIGN_MS     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EDGE_TIMEOUT = 2'd2;

  // start stages
  localparam logic [STAGE_W-1:0] ST_IDLE  = 3'd0;
  localparam logic [STAGE_W-1:0] ST_ALIGN = 3'd2;
  localparam logic [STAGE_W-1:0] ST_KICK  = 3'd3;
  localparam logic [STAGE_W-1:0] ST_WAIT  = 3'd4;
  localparam logic [STAGE_W-1:0] ST_TRACK = 3'd5;

  // fault codes
  localparam logic [FAULT_W-1:0] FAULT_NONE    = 2'd0;
  localparam logic [FAULT_W-1:0] FAULT_HALL    = 2'd1;
  localparam logic [FAULT_W-1:0] FAULT_BREAK   = 2'd2;
  localparam logic [FAULT_W-1:0] FAULT_TIMEOUT = 2'd3;

  localparam logic [KICK_W-1:0] KICK_STEPS = 3'd6;

  // register reset values
  localparam logic [DUTY_W-1:0] PWM_PERIOD_RST   = 16'd999;
  localparam logic [MS_W-1:0]   ALIGN_MS_RST     = 10'd80;
  localparam logic [MS_W-1:0]   EDGE_TIMEOUT_RST = 10'd300;

  localparam int unsigned PWM_BASE_RST = 32'(PWM_PERIOD_RST) + 1;
  localparam logic [DUTY_W-1:0] ASSIST5_RST  = DUTY_W'(PWM_BASE_RST * 5 / 100);
  localparam logic [DUTY_W-1:0] ASSIST8_RST  = DUTY_W'(PWM_BASE_RST * 8 / 100);
  localparam logic [DUTY_W-1:0] ASSIST10_RST = DUTY_W'(PWM_BASE_RST * 10 / 100);

  // x / 100 == (x * RECIP_MUL) >> RECIP_SHIFT, exact for x below 2^20
  localparam int BASE_W = DUTY_W + 1;
  localparam int RECIP_W = 21;
  localparam logic [RECIP_W-1:0] RECIP_MUL = 21'd1342178;
  localparam int RECIP_SHIFT = 27;
  localparam int PROD_W = BASE_W + RECIP_W;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [DUTY_W-1:0] duty_request;
    logic              spin_direction;
    logic [HALL_W-1:0] sensed_hall;
    logic              break_flag;
    logic              transition_ok;
  } in_item_t;

  typedef struct packed {
    logic               drive_enable;
    logic [HALL_W-1:0]  drive_hall;
    logic [DUTY_W-1:0]  drive_duty;
    logic [STAGE_W-1:0] start_stage;
    logic [KICK_W-1:0]  kick_index;
    logic [FAULT_W-1:0] fault_code;
    logic               is_running;
  } out_item_t;

  typedef struct packed {
    logic [DUTY_W-1:0] pwm_period;
    logic [MS_W-1:0]   align_ms;
    logic [MS_W-1:0]   edge_timeout_ms;
  } cfg_t;

  // start duties at 5, 8 and 10 percent of pwm_period + 1
  typedef struct packed {
    logic [DUTY_W-1:0] pct5;
    logic [DUTY_W-1:0] pct8;
    logic [DUTY_W-1:0] pct10;
  } assist_t;

  function automatic logic hall_valid(input logic [HALL_W-1:0] h);
    return (h != 3'd0) && (h != 3'd7);
  endfunction

  // next pattern of the commutation sequence for a direction
  function automatic logic [HALL_W-1:0] next_hall(input logic dir,
                                                  input logic [HALL_W-1:0] h);
    logic [HALL_W-1:0] n;
    case (h)
      3'd1: n = dir ? 3'd5 : 3'd3;
      3'd2: n = dir ? 3'd3 : 3'd6;
      3'd3: n = dir ? 3'd1 : 3'd2;
      3'd4: n = dir ? 3'd6 : 3'd5;
      3'd5: n = dir ? 3'd4 : 3'd1;
      3'd6: n = dir ? 3'd2 : 3'd4;
      default: n = 3'd0;
    endcase
    return n;
  endfunction

  // kick step length in ms, last entry holds for higher steps
  function automatic logic [MS_W-1:0] kick_delay(input logic [KICK_W-1:0] idx);
    logic [MS_W-1:0] d;
    case (idx)
      3'd0: d = 10'd20;
      3'd1: d = 10'd16;
      3'd2: d = 10'd14;
      3'd3: d = 10'd12;
      3'd4: d = 10'd10;
      default: d = 10'd8;
    endcase
    return d;
  endfunction

endpackage
`default_nettype wire

@@ sv/hbac_if.sv @@
`default_nettype none
// request channel into the commutator
interface hbac_in_if;
  logic                             valid;
  logic                             ready;
  logic [hbac_pkg::OP_W-1:0]        operation;
  logic [hbac_pkg::DUTY_W-1:0]      duty_request;
  logic                             spin_direction;
  logic [hbac_pkg::HALL_W-1:0]      sensed_hall;
  logic                             break_flag;
  logic                             transition_ok;

  modport source (output valid, operation, duty_request, spin_direction, sensed_hall,
                  break_flag, transition_ok, input ready);
  modport sink (input valid, operation, duty_request, spin_direction, sensed_hall,
                break_flag, transition_ok, output ready);
endinterface

// result channel out of the commutator
interface hbac_out_if;
  logic                             valid;
  logic                             ready;
  logic                             drive_enable;
  logic [hbac_pkg::HALL_W-1:0]      drive_hall;
  logic [hbac_pkg::DUTY_W-1:0]      drive_duty;
  logic [hbac_pkg::STAGE_W-1:0]     start_stage;
  logic [hbac_pkg::KICK_W-1:0]      kick_index;
  logic [hbac_pkg::FAULT_W-1:0]     fault_code;
  logic                             is_running;

  modport source (output valid, drive_enable, drive_hall, drive_duty, start_stage,
                  kick_index, fault_code, is_running, input ready);
  modport sink (input valid, drive_enable, drive_hall, drive_duty, start_stage,
                kick_index, fault_code, is_running, output ready);
endinterface
`default_nettype wire

@@ sv/hall_bldc_assisted_start_commutator.sv @@
// Six-step hall commutator with align and kick start. Each request (simple start,
// assisted start, stop, millisecond tick, hall edge, set duty) yields exactly one
// result showing drive state after that request. Throughput is one request per
// clock while results are taken; a request passes the input register, then the
// combinational state update, then the result register. A stalled result
// still lets one more request enter the input register. Registers on the cfg_
// port take effect for the next request; the 5/8/10 percent start duties are
// recomputed from pwm_period in the same cycle it is written. No clearing pass
// after reset.
`default_nettype none
`include "hall_bldc_assisted_start_commutator_defines.svh"
module hall_bldc_assisted_start_commutator (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  hbac_in_if.sink                              in_ch,
  hbac_out_if.source                           out_ch,
  input  wire logic                            cfg_we,
  input  wire logic [hbac_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [hbac_pkg::DUTY_W-1:0]     cfg_wdata
);

  hbac_pkg::cfg_t      cfg;
  hbac_pkg::assist_t   assist;
  hbac_pkg::in_item_t  a_item_r;
  hbac_pkg::out_item_t out_item_r;
  hbac_pkg::out_item_t result;

  logic a_v_r;
  logic out_v_r;
  logic advance;
  logic in_ready;

  // request moves from input register into the state update and result register
  assign advance  = a_v_r && (!out_v_r || out_ch.ready);
  assign in_ready = !a_v_r || advance;
  assign in_ch.ready = in_ready;

  // configuration registers and start duty precompute
  hbac_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg),
    .assist    (assist)
  );

  // start sequencer state and one-request update
  hbac_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .item    (a_item_r),
    .cfg     (cfg),
    .assist  (assist),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r   <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_ready) begin
        a_v_r <= in_ch.valid;
      end
      if (advance) begin
        out_v_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_ready && in_ch.valid) begin
      a_item_r.operation      <= in_ch.operation;
      a_item_r.duty_request   <= in_ch.duty_request;
      a_item_r.spin_direction <= in_ch.spin_direction;
      a_item_r.sensed_hall    <= in_ch.sensed_hall;
      a_item_r.break_flag     <= in_ch.break_flag;
      a_item_r.transition_ok  <= in_ch.transition_ok;
    end
    if (advance) begin
      out_item_r <= result;
    end
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.drive_enable = out_item_r.drive_enable;
  assign out_ch.drive_hall   = out_item_r.drive_hall;
  assign out_ch.drive_duty   = out_item_r.drive_duty;
  assign out_ch.start_stage  = out_item_r.start_stage;
  assign out_ch.kick_index   = out_item_r.kick_index;
  assign out_ch.fault_code   = out_item_r.fault_code;
  assign out_ch.is_running   = out_item_r.is_running;

  // enabled drive always means running, fault free, with a live pattern
  `HBAC_ASSERT_NOW(a_enable_safe, out_v_r && out_item_r.drive_enable, out_item_r.is_running && (out_item_r.fault_code == hbac_pkg::FAULT_NONE) && (out_item_r.drive_hall != '0))
  // any fault leaves the drive shut down and idle
  `HBAC_ASSERT_NOW(a_fault_halts, out_v_r && (out_item_r.fault_code != hbac_pkg::FAULT_NONE), !out_item_r.is_running && !out_item_r.drive_enable && (out_item_r.start_stage == hbac_pkg::ST_IDLE))
  // a stop request shows up as an idle, dead drive in the next result
  `HBAC_ASSERT_NEXT(a_stop_idles, advance && (a_item_r.operation == hbac_pkg::OP_STOP), out_v_r && (out_item_r.start_stage == hbac_pkg::ST_IDLE) && !out_item_r.drive_enable && (out_item_r.drive_duty == '0))
  // kick step number stays within the step table while kicking
  `HBAC_ASSERT_NOW(a_kick_range, out_v_r && (out_item_r.start_stage == hbac_pkg::ST_KICK), (out_item_r.kick_index != '0) && (out_item_r.kick_index <= hbac_pkg::KICK_STEPS))

endmodule
`default_nettype wire

@@ sv/hbac_cfg.sv @@
`default_nettype none
module hbac_cfg (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_we,
  input  wire logic [hbac_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [hbac_pkg::DUTY_W-1:0]        cfg_wdata,
  output hbac_pkg::cfg_t                          cfg,
  output hbac_pkg::assist_t                       assist
);

  hbac_pkg::cfg_t    cfg_r, cfg_nxt;
  hbac_pkg::assist_t assist_r, assist_nxt;

  logic [hbac_pkg::BASE_W-1:0] base;
  logic [hbac_pkg::PROD_W-1:0] scaled;
  logic [hbac_pkg::PROD_W+2:0] scaled5;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        hbac_pkg::CFG_PWM_PERIOD:   cfg_nxt.pwm_period = cfg_wdata;
        hbac_pkg::CFG_ALIGN_MS:     cfg_nxt.align_ms = cfg_wdata[hbac_pkg::MS_W-1:0];
        hbac_pkg::CFG_EDGE_TIMEOUT: cfg_nxt.edge_timeout_ms = cfg_wdata[hbac_pkg::MS_W-1:0];
        default: ;
      endcase
    end
  end

  // start duties follow the period written in the same cycle
  assign base    = {1'b0, cfg_nxt.pwm_period} + hbac_pkg::BASE_W'(1);
  assign scaled  = {{hbac_pkg::RECIP_W{1'b0}}, base} *
                   {{hbac_pkg::BASE_W{1'b0}}, hbac_pkg::RECIP_MUL};
  assign scaled5 = {scaled, 2'b00} + {3'b000, scaled};

  always_comb begin
    assist_nxt.pct5  = hbac_pkg::DUTY_W'(scaled5 >> hbac_pkg::RECIP_SHIFT);
    assist_nxt.pct8  = hbac_pkg::DUTY_W'(scaled >> (hbac_pkg::RECIP_SHIFT - 3));
    assist_nxt.pct10 = hbac_pkg::DUTY_W'(scaled5 >> (hbac_pkg::RECIP_SHIFT - 1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pwm_period      <= hbac_pkg::PWM_PERIOD_RST;
      cfg_r.align_ms        <= hbac_pkg::ALIGN_MS_RST;
      cfg_r.edge_timeout_ms <= hbac_pkg::EDGE_TIMEOUT_RST;
      assist_r.pct5         <= hbac_pkg::ASSIST5_RST;
      assist_r.pct8         <= hbac_pkg::ASSIST8_RST;
      assist_r.pct10        <= hbac_pkg::ASSIST10_RST;
    end else begin
      cfg_r    <= cfg_nxt;
      assist_r <= assist_nxt;
    end
  end

  assign cfg    = cfg_r;
  assign assist = assist_r;

endmodule
`default_nettype wire

@@ sv/hbac_core.sv @@
`default_nettype none
module hbac_core (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 advance,
  input  wire hbac_pkg::in_item_t   item,
  input  wire hbac_pkg::cfg_t       cfg,
  input  wire hbac_pkg::assist_t    assist,
  output hbac_pkg::out_item_t       result
);

  logic [hbac_pkg::STAGE_W-1:0] stage_r, stage_nxt;
  logic [hbac_pkg::KICK_W-1:0]  kick_r, kick_nxt;
  logic [hbac_pkg::MS_W-1:0]    ms_r, ms_nxt;
  logic [hbac_pkg::HALL_W-1:0]  forced_r, forced_nxt;
  logic                         dir_r, dir_nxt;
  logic [hbac_pkg::DUTY_W-1:0]  duty_r, duty_nxt;
  logic [hbac_pkg::DUTY_W-1:0]  target_r, target_nxt;
  logic                         running_r, running_nxt;
  logic [hbac_pkg::FAULT_W-1:0] fault_r, fault_nxt;
  logic                         enable_r, enable_nxt;
  logic [hbac_pkg::HALL_W-1:0]  applied_r, applied_nxt;

  logic [hbac_pkg::DUTY_W-1:0]  req_clamped;
  logic [hbac_pkg::MS_W-1:0]    ms_bump;
  logic [hbac_pkg::HALL_W-1:0]  kick_hall;
  logic [hbac_pkg::KICK_W-1:0]  kick_idx;
  logic                         commutating;
  logic                         halt;

  assign req_clamped = (item.duty_request > cfg.pwm_period) ? cfg.pwm_period
                                                            : item.duty_request;
  assign ms_bump     = (ms_r == '1) ? ms_r : ms_r + hbac_pkg::MS_W'(1);
  assign kick_hall   = hbac_pkg::next_hall(dir_r, forced_r);
  assign kick_idx    = (kick_r == '0) ? '0 : kick_r - hbac_pkg::KICK_W'(1);
  assign commutating = running_r &&
                       ((stage_r == hbac_pkg::ST_WAIT) || (stage_r == hbac_pkg::ST_TRACK));

  always_comb begin
    stage_nxt   = stage_r;
    kick_nxt    = kick_r;
    ms_nxt      = ms_r;
    forced_nxt  = forced_r;
    dir_nxt     = dir_r;
    duty_nxt    = duty_r;
    target_nxt  = target_r;
    running_nxt = running_r;
    fault_nxt   = fault_r;
    enable_nxt  = enable_r;
    applied_nxt = applied_r;
    halt        = 1'b0;

    case (item.operation)
      hbac_pkg::OP_START_SIMPLE, hbac_pkg::OP_START_ASSIST: begin
        kick_nxt    = '0;
        ms_nxt      = '0;
        fault_nxt   = hbac_pkg::FAULT_NONE;
        dir_nxt     = item.spin_direction;
        target_nxt  = req_clamped;
        running_nxt = 1'b1;
        enable_nxt  = 1'b0;
        applied_nxt = '0;
        if (item.operation == hbac_pkg::OP_START_SIMPLE) begin
          duty_nxt  = req_clamped;
          stage_nxt = hbac_pkg::ST_TRACK;
        end else begin
          duty_nxt  = assist.pct5;
          stage_nxt = hbac_pkg::ST_ALIGN;
        end
        if (hbac_pkg::hall_valid(item.sensed_hall)) begin
          applied_nxt = item.sensed_hall;
          enable_nxt  = 1'b1;
          if (item.operation == hbac_pkg::OP_START_ASSIST) begin
            forced_nxt = item.sensed_hall;
          end
        end else begin
          fault_nxt = hbac_pkg::FAULT_HALL;
          halt      = 1'b1;
        end
      end

      hbac_pkg::OP_STOP: begin
        halt = 1'b1;
      end

      hbac_pkg::OP_TICK: begin
        case (stage_r)
          hbac_pkg::ST_ALIGN, hbac_pkg::ST_KICK: begin
            ms_nxt = ms_bump;
            if (ms_bump >= ((stage_r == hbac_pkg::ST_ALIGN) ? cfg.align_ms
                                                            : hbac_pkg::kick_delay(kick_idx)))
            begin
              if (item.break_flag) begin
                fault_nxt = hbac_pkg::FAULT_BREAK;
                halt      = 1'b1;
              end else if ((stage_r == hbac_pkg::ST_ALIGN) ||
                           (kick_r < hbac_pkg::KICK_STEPS)) begin
                // force the next step of the sequence
                if (hbac_pkg::hall_valid(kick_hall)) begin
                  forced_nxt  = kick_hall;
                  kick_nxt    = (stage_r == hbac_pkg::ST_ALIGN) ? hbac_pkg::KICK_W'(1)
                                                                : kick_r + hbac_pkg::KICK_W'(1);
                  stage_nxt   = hbac_pkg::ST_KICK;
                  ms_nxt      = '0;
                  applied_nxt = kick_hall;
                end else begin
                  fault_nxt = hbac_pkg::FAULT_HALL;
                  halt      = 1'b1;
                end
              end else begin
                // kick done, look for a real transition
                kick_nxt  = '0;
                stage_nxt = hbac_pkg::ST_WAIT;
                ms_nxt    = '0;
                if (!hbac_pkg::hall_valid(item.sensed_hall)) begin
                  fault_nxt = hbac_pkg::FAULT_HALL;
                  halt      = 1'b1;
                end else begin
                  applied_nxt = item.sensed_hall;
                  if (item.transition_ok) begin
                    duty_nxt  = target_r;
                    stage_nxt = hbac_pkg::ST_TRACK;
                  end
                end
              end
            end
          end
          hbac_pkg::ST_WAIT: begin
            if (item.transition_ok) begin
              duty_nxt  = target_r;
              stage_nxt = hbac_pkg::ST_TRACK;
              ms_nxt    = '0;
              if (!hbac_pkg::hall_valid(item.sensed_hall)) begin
                fault_nxt = hbac_pkg::FAULT_HALL;
                halt      = 1'b1;
              end else if (item.break_flag) begin
                applied_nxt = item.sensed_hall;
                fault_nxt   = hbac_pkg::FAULT_BREAK;
                halt        = 1'b1;
              end else begin
                applied_nxt = item.sensed_hall;
              end
            end else begin
              ms_nxt = ms_bump;
              if (ms_bump >= cfg.edge_timeout_ms) begin
                fault_nxt = hbac_pkg::FAULT_TIMEOUT;
                halt      = 1'b1;
              end
            end
          end
          default: ;
        endcase
      end

      hbac_pkg::OP_HALL_EDGE, hbac_pkg::OP_SET_DUTY: begin
        if (item.operation == hbac_pkg::OP_SET_DUTY) begin
          duty_nxt = req_clamped;
        end
        if (commutating) begin
          if (hbac_pkg::hall_valid(item.sensed_hall)) begin
            applied_nxt = item.sensed_hall;
          end else begin
            fault_nxt = hbac_pkg::FAULT_HALL;
            halt      = 1'b1;
          end
        end
      end

      default: ;
    endcase

    // drive shutdown, common to stop and every fault
    if (halt) begin
      running_nxt = 1'b0;
      enable_nxt  = 1'b0;
      applied_nxt = '0;
      stage_nxt   = hbac_pkg::ST_IDLE;
      kick_nxt    = '0;
      ms_nxt      = '0;
    end
  end

  always_comb begin
    result.drive_enable = enable_nxt;
    result.drive_hall   = applied_nxt;
    result.start_stage  = stage_nxt;
    result.kick_index   = (stage_nxt == hbac_pkg::ST_KICK) ? kick_nxt : '0;
    result.fault_code   = fault_nxt;
    result.is_running   = running_nxt;
    if (applied_nxt == '0) begin
      result.drive_duty = '0;
    end else if (stage_nxt == hbac_pkg::ST_ALIGN) begin
      result.drive_duty = assist.pct5;
    end else if (stage_nxt == hbac_pkg::ST_KICK) begin
      if (kick_nxt <= hbac_pkg::KICK_W'(2)) begin
        result.drive_duty = assist.pct5;
      end else if (kick_nxt <= hbac_pkg::KICK_W'(4)) begin
        result.drive_duty = assist.pct8;
      end else begin
        result.drive_duty = assist.pct10;
      end
    end else begin
      result.drive_duty = duty_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r   <= hbac_pkg::ST_IDLE;
      kick_r    <= '0;
      ms_r      <= '0;
      forced_r  <= '0;
      dir_r     <= 1'b0;
      duty_r    <= '0;
      target_r  <= '0;
      running_r <= 1'b0;
      fault_r   <= hbac_pkg::FAULT_NONE;
      enable_r  <= 1'b0;
      applied_r <= '0;
    end else if (advance) begin
      stage_r   <= stage_nxt;
      kick_r    <= kick_nxt;
      ms_r      <= ms_nxt;
      forced_r  <= forced_nxt;
      dir_r     <= dir_nxt;
      duty_r    <= duty_nxt;
      target_r  <= target_nxt;
      running_r <= running_nxt;
      fault_r   <= fault_nxt;
      enable_r  <= enable_nxt;
      applied_r <= applied_nxt;
    end
  end

endmodule
`default_nettype wire
